// ===== hdl/dm_pkg.sv =====
// Shared types, constants and helper functions for the matrix determinant block.
// No dependencies; every other file of the block imports this package.
package dm_pkg;

  localparam int MAX_ORDER  = 5;
  localparam int ENTRY_BITS = 12;
  localparam int ENTRY_W    = 12;
  localparam int DET_W      = 63;
  localparam int ORDER_W    = 3;
  localparam int CELLS      = MAX_ORDER * MAX_ORDER;
  localparam int CELL_AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int SUBSETS    = 1 << MAX_ORDER;
  localparam int IDX_W      = $clog2(MAX_ORDER + 1);

  typedef logic signed [ENTRY_W-1:0] entry_t;
  typedef logic signed [DET_W-1:0]   det_t;
  typedef logic [ORDER_W-1:0]        order_t;
  typedef logic [CELL_AW-1:0]        cell_addr_t;
  typedef logic [MAX_ORDER-1:0]      subset_t;
  typedef logic [IDX_W-1:0]          idx_t;

  typedef struct packed {
    logic   start;
    logic   take;
    order_t order;
  } eng_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } eng_stat_t;

  function automatic order_t clamp_order(order_t v);
    order_t r;
    r = v;
    if (v == '0) r = order_t'(1);
    if (v > order_t'(MAX_ORDER)) r = order_t'(MAX_ORDER);
    return r;
  endfunction

  // Keep the low ENTRY_BITS bits and sign-extend them to the full entry width.
  function automatic entry_t sext_entry(entry_t raw);
    entry_t r;
    for (int i = 0; i < ENTRY_W; i++) begin
      r[i] = (i < ENTRY_BITS) ? raw[i] : raw[ENTRY_BITS-1];
    end
    return r;
  endfunction

endpackage

// ===== hdl/dm_if.sv =====
// Valid/ready channel interfaces for entries, results and the order register.
// Depends on dm_pkg for the payload types.
interface dm_entry_if;
  import dm_pkg::*;
  logic   valid;
  logic   ready;
  entry_t entry_value;
  modport source (output valid, output entry_value, input ready);
  modport sink   (input valid, input entry_value, output ready);
endinterface

interface dm_det_if;
  import dm_pkg::*;
  logic valid;
  logic ready;
  det_t determinant;
  modport source (output valid, output determinant, input ready);
  modport sink   (input valid, input determinant, output ready);
endinterface

interface dm_cfg_if;
  import dm_pkg::*;
  logic   valid;
  logic   ready;
  order_t matrix_order;
  modport source (output valid, output matrix_order, input ready);
  modport sink   (input valid, input matrix_order, output ready);
endinterface

// ===== hdl/matrix_determinant.sv =====
// Top level of the matrix determinant block: loader, entry store, engine, result register.
// Depends on dm_pkg, dm_if, dm_store and dm_engine.
//
//  channel   direction  payload                 meaning
//  entry     in         entry_value  [11:0] s   one matrix entry, row-major order
//  result    out        determinant  [62:0] s   exact determinant of the loaded matrix
//  cfg       in         matrix_order [2:0]  u   order of the next matrix (1 to 5)
//
// While loading, the block accepts one entry per cycle. After the last entry the engine
// walks every nonempty column subset of the matrix in numeric order, and the single
// multiplier and the one read port of the minor memory serve every subset in turn.
// Entry ready returns in the cycle after the engine hands off its result.
// Reset is synchronous and clears the order to 3 and the entry count to zero.
// A waiting result does not block loading of the next matrix; only a second
// determinant waits in the engine until the result register is free. The order
// register accepts a write only while loading and with the engine idle.
module matrix_determinant (
  input  logic        clk,
  input  logic        rst,
  dm_entry_if.sink    entry,
  dm_det_if.source    result,
  dm_cfg_if.sink      cfg
);
  import dm_pkg::*;

  typedef enum logic [1:0] {T_LOAD, T_CALC} state_t;

  state_t     state;
  order_t     order;
  idx_t       row, col;
  logic       entry_acc, last_entry, slot_free;
  cell_addr_t wr_addr, rd_addr;
  entry_t     rd_data;
  eng_cmd_t   cmd;
  eng_stat_t  stat;
  det_t       eng_det;
  logic       start;

  assign entry.ready = (state == T_LOAD);
  assign cfg.ready   = (state == T_LOAD) && !stat.busy;
  assign entry_acc   = entry.valid && entry.ready;
  assign last_entry  = (row == idx_t'(order - order_t'(1))) &&
                       (col == idx_t'(order - order_t'(1)));
  assign wr_addr     = cell_addr_t'(int'(row) * MAX_ORDER + int'(col));
  assign slot_free   = !result.valid || result.ready;

  assign cmd.start = start;
  assign cmd.take  = stat.done && slot_free;
  assign cmd.order = order;

  dm_store u_store (
    .clk     (clk),
    .wr_en   (entry_acc),
    .wr_addr (wr_addr),
    .wr_data (sext_entry(entry.entry_value)),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  dm_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cell_addr (rd_addr),
    .cell_data (rd_data),
    .det       (eng_det)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= T_LOAD;
      order        <= order_t'(3);
      row          <= '0;
      col          <= '0;
      start        <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      start <= 1'b0;
      // A new determinant takes the slot; otherwise an accepted one frees it.
      if (cmd.take) begin
        result.valid       <= 1'b1;
        result.determinant <= eng_det;
      end else if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      if (cfg.valid && cfg.ready) begin
        // A new order drops any partly loaded matrix.
        order <= clamp_order(cfg.matrix_order);
        row   <= '0;
        col   <= '0;
      end else if (entry_acc) begin
        if (col == idx_t'(order - order_t'(1))) begin
          col <= '0;
          row <= last_entry ? '0 : row + idx_t'(1);
        end else begin
          col <= col + idx_t'(1);
        end
      end
      case (state)
        T_LOAD: begin
          // Loading resumes only when the engine has handed off its last result.
          if (entry_acc && last_entry) begin
            start <= 1'b1;
            state <= T_CALC;
          end
        end
        T_CALC: begin
          if (cmd.take) state <= T_LOAD;
        end
        default: state <= T_LOAD;
      endcase
    end
  end

endmodule

// ===== hdl/dm_store.sv =====
// Matrix entry store: one write port, one registered read port.
// Depends on dm_pkg.
module dm_store (
  input  logic                clk,
  input  logic                wr_en,
  input  dm_pkg::cell_addr_t  wr_addr,
  input  dm_pkg::entry_t      wr_data,
  input  dm_pkg::cell_addr_t  rd_addr,
  output dm_pkg::entry_t      rd_data
);
  import dm_pkg::*;

  entry_t mem [CELLS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/dm_engine.sv =====
// Cofactor expansion sequencer with a minor-determinant memory indexed by column subset.
// Depends on dm_pkg; reads matrix entries through the dm_store read port.
module dm_engine (
  input  logic                clk,
  input  logic                rst,
  input  dm_pkg::eng_cmd_t    cmd,
  output dm_pkg::eng_stat_t   stat,
  output dm_pkg::cell_addr_t  cell_addr,
  input  dm_pkg::entry_t      cell_data,
  output dm_pkg::det_t        det
);
  import dm_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SEED, S_ISSUE, S_DRAIN1, S_DRAIN2, S_WRITE, S_FINISH}
    state_t;

  state_t  state;
  order_t  order;
  subset_t mask;
  idx_t    col;
  det_t    acc;
  det_t    prod;
  logic    s1_valid, s1_neg, s2_valid, s2_neg;

  det_t    dp [SUBSETS];
  det_t    dp_q;
  subset_t dp_rd_addr;
  subset_t full_mask;
  logic    issuing, dp_wr_en;
  subset_t dp_wr_addr;
  det_t    dp_wr_data;
  idx_t    pc;
  logic    par;

  // dp[S] holds the determinant of the minor built from the last |S| rows and columns S.
  always_comb begin
    pc  = '0;
    par = 1'b0;
    for (int i = 0; i < MAX_ORDER; i++) begin
      pc = pc + idx_t'(mask[i]);
      if (i < int'(col)) par = par ^ mask[i];
    end
    full_mask  = subset_t'((SUBSETS'(1) << order) - 1);
    issuing    = (state == S_ISSUE);
    dp_rd_addr = mask & ~(subset_t'(1) << col);
    cell_addr  = cell_addr_t'((int'(order) - int'(pc)) * MAX_ORDER + int'(col));
    dp_wr_en   = (state == S_SEED) || (state == S_WRITE);
    dp_wr_addr = (state == S_SEED) ? '0 : mask;
    dp_wr_data = (state == S_SEED) ? det_t'(1) : acc;
    stat.busy  = (state != S_IDLE);
    stat.done  = (state == S_FINISH);
    det        = acc;
  end

  always_ff @(posedge clk) begin
    if (dp_wr_en) begin
      dp[dp_wr_addr] <= dp_wr_data;
    end
    dp_q <= dp[dp_rd_addr];
    prod <= det_t'(cell_data) * dp_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      order    <= order_t'(1);
      mask     <= '0;
      col      <= '0;
      acc      <= '0;
      s1_valid <= 1'b0;
      s1_neg   <= 1'b0;
      s2_valid <= 1'b0;
      s2_neg   <= 1'b0;
    end else begin
      s1_valid <= issuing && mask[col];
      s1_neg   <= par;
      s2_valid <= s1_valid;
      s2_neg   <= s1_neg;
      if (s2_valid) begin
        acc <= s2_neg ? acc - prod : acc + prod;
      end
      case (state)
        S_IDLE: begin
          if (cmd.start) begin
            order <= cmd.order;
            state <= S_SEED;
          end
        end
        S_SEED: begin
          mask  <= subset_t'(1);
          col   <= '0;
          acc   <= '0;
          state <= S_ISSUE;
        end
        S_ISSUE: begin
          if (col == idx_t'(order - order_t'(1))) begin
            state <= S_DRAIN1;
          end else begin
            col <= col + idx_t'(1);
          end
        end
        S_DRAIN1: state <= S_DRAIN2;
        S_DRAIN2: state <= S_WRITE;
        S_WRITE: begin
          col <= '0;
          if (mask == full_mask) begin
            state <= S_FINISH;
          end else begin
            acc   <= '0;
            mask  <= mask + subset_t'(1);
            state <= S_ISSUE;
          end
        end
        S_FINISH: begin
          if (cmd.take) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
